### hdl/dlts_pkg.sv
// Shared types, request codes and timing constants for the display line timing block.
package dlts_pkg;

  localparam int unsigned LineW = 9;
  localparam int unsigned RegW  = 16;

  localparam logic [LineW-1:0] VisibleLines  = 9'd192;
  localparam logic [LineW-1:0] TotalLines    = 9'd263;
  localparam logic [LineW-1:0] LastLine      = 9'd262;
  localparam logic [LineW-1:0] Render3dLine  = 9'd215;
  localparam logic [LineW-1:0] DispStartLo   = 9'd1;
  localparam logic [LineW-1:0] DispStartHi   = 9'd194;

  localparam logic [RegW-1:0] StatWrMask  = 16'hffbf;
  localparam logic [RegW-1:0] PowerWrMask = 16'h820f;

  localparam int unsigned StVblank    = 0;
  localparam int unsigned StHblank    = 1;
  localparam int unsigned StMatch     = 2;
  localparam int unsigned StVblankIe  = 3;
  localparam int unsigned StHblankIe  = 4;
  localparam int unsigned StMatchIe   = 5;
  localparam int unsigned StCmpHi     = 7;

  localparam int unsigned IrqVblank = 0;
  localparam int unsigned IrqHblank = 1;
  localparam int unsigned IrqMatch  = 2;

  typedef enum logic [2:0] {
    REQ_READ_STATUS  = 3'd0,
    REQ_WRITE_STATUS = 3'd1,
    REQ_WRITE_LINE   = 3'd2,
    REQ_WRITE_POWER  = 3'd3,
    REQ_LINE_START   = 3'd4,
    REQ_LINE_END     = 3'd5
  } dlts_req_e;

  typedef struct packed {
    logic [RegW-1:0] write_mask;
    logic [RegW-1:0] write_data;
    logic            cpu_sel;
    logic [2:0]      req_type;
  } dlts_item_t;

  typedef struct packed {
    logic             screens_swapped;
    logic [LineW-1:0] current_line;
    logic             render_line;
    logic             swap_buffers;
    logic             render_3d;
    logic             dma_display_start;
    logic             dma_vblank;
    logic             dma_hblank;
    logic [2:0]       cpu1_irq;
    logic [2:0]       cpu0_irq;
    logic [RegW-1:0]  read_data;
  } dlts_result_t;

  function automatic logic [LineW-1:0] compare_of(input logic [RegW-1:0] s);
    return {s[StCmpHi], s[15:8]};
  endfunction

endpackage

### hdl/dlts_core.sv
// Line counter, status and power registers with the per-transaction update logic.
module dlts_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlts_pkg::dlts_item_t item_i,
  input  logic                 fire_i,
  output dlts_pkg::dlts_result_t result_o
);
  import dlts_pkg::*;

  logic [LineW-1:0] line_q, line_d;
  logic [RegW-1:0]  stat0_q, stat0_d;
  logic [RegW-1:0]  stat1_q, stat1_d;
  logic [RegW-1:0]  power_q, power_d;
  logic [RegW-1:0]  sel_stat;
  logic [RegW-1:0]  smask;
  logic [RegW-1:0]  pmask;
  logic [LineW-1:0] next_line;
  dlts_result_t     res;

  assign sel_stat  = item_i.cpu_sel ? stat1_q : stat0_q;
  assign smask     = item_i.write_mask & StatWrMask;
  assign pmask     = item_i.write_mask & PowerWrMask;
  assign next_line = ((line_q + 9'd1) == TotalLines) ? '0 : line_q + 9'd1;

  always_comb begin
    line_d  = line_q;
    stat0_d = stat0_q;
    stat1_d = stat1_q;
    power_d = power_q;
    res     = '0;
    case (item_i.req_type)
      REQ_READ_STATUS: begin
        res.read_data = sel_stat;
      end
      REQ_WRITE_STATUS: begin
        if (item_i.cpu_sel) begin
          stat1_d = (stat1_q & ~smask) | (item_i.write_data & smask);
        end else begin
          stat0_d = (stat0_q & ~smask) | (item_i.write_data & smask);
        end
      end
      REQ_WRITE_LINE: begin
        line_d = (line_q & ~item_i.write_mask[LineW-1:0])
               | (item_i.write_data[LineW-1:0] & item_i.write_mask[LineW-1:0]);
      end
      REQ_WRITE_POWER: begin
        power_d = (power_q & ~pmask) | (item_i.write_data & pmask);
      end
      REQ_LINE_START: begin
        stat0_d[StHblank] = 1'b1;
        stat1_d[StHblank] = 1'b1;
        res.render_line       = line_q < VisibleLines;
        res.dma_hblank        = line_q < VisibleLines;
        res.cpu0_irq[IrqHblank] = stat0_q[StHblankIe];
        res.cpu1_irq[IrqHblank] = stat1_q[StHblankIe];
        res.render_3d         = line_q == Render3dLine;
        res.dma_display_start = (line_q > DispStartLo) && (line_q < DispStartHi);
      end
      REQ_LINE_END: begin
        line_d = next_line;
        stat0_d[StHblank] = 1'b0;
        stat1_d[StHblank] = 1'b0;
        if (next_line == VisibleLines) begin
          stat0_d[StVblank] = 1'b1;
          stat1_d[StVblank] = 1'b1;
          res.cpu0_irq[IrqVblank] = stat0_q[StVblankIe];
          res.cpu1_irq[IrqVblank] = stat1_q[StVblankIe];
          res.dma_vblank   = 1'b1;
          res.swap_buffers = 1'b1;
        end else if (next_line == LastLine) begin
          stat0_d[StVblank] = 1'b0;
          stat1_d[StVblank] = 1'b0;
        end
        stat0_d[StMatch] = compare_of(stat0_q) == next_line;
        stat1_d[StMatch] = compare_of(stat1_q) == next_line;
        res.cpu0_irq[IrqMatch] = stat0_d[StMatch] & stat0_q[StMatchIe];
        res.cpu1_irq[IrqMatch] = stat1_d[StMatch] & stat1_q[StMatchIe];
      end
      default: begin
      end
    endcase
    res.current_line    = line_d;
    res.screens_swapped = power_d[15];
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      stat0_q <= '0;
      stat1_q <= '0;
      power_q <= '0;
    end else if (fire_i) begin
      line_q  <= line_d;
      stat0_q <= stat0_d;
      stat1_q <= stat1_d;
      power_q <= power_d;
    end
  end

endmodule

### hdl/dlts_out_stage.sv
// Result register that holds a finished transaction until the master side takes it.
module dlts_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  dlts_pkg::dlts_result_t result_i,
  input  logic                   take_i,
  output logic                   valid_o,
  output dlts_pkg::dlts_result_t result_o
);
  import dlts_pkg::*;

  logic         valid_q, valid_d;
  dlts_result_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

### hdl/display_line_timing_status.sv
// Top level of the display line timing and status block.
//
//   channel   dir  tdata                          tuser
//   s_axis    in   write_data, write_mask         req_type, cpu_sel
//   m_axis    out  read_data .. screens_swapped   -
//
// One transaction per cycle sustained while m_axis_tready stays high.
// The input register feeds the register update logic, which loads the result register.
// A stalled result register holds the input register, which then drops s_axis_tready.
// Reset clears the line counter, both status registers and the power register.
module display_line_timing_status (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // write_data[15:0], write_mask[31:16]
  input  logic [3:0]  s_axis_tuser,   // req_type[2:0], cpu_sel[3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // read_data[15:0], cpu0_irq[18:16], cpu1_irq[21:19],
                                      // dma_hblank[22], dma_vblank[23],
                                      // dma_display_start[24], render_3d[25],
                                      // swap_buffers[26], render_line[27],
                                      // current_line[36:28], screens_swapped[37], zero[39:38]
);
  import dlts_pkg::*;

  logic         in_valid_q, in_valid_d;
  dlts_item_t   in_item_q;
  logic         fire;
  logic         out_valid;
  dlts_result_t core_res;
  dlts_result_t out_res;

  assign fire          = in_valid_q && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.req_type   <= s_axis_tuser[2:0];
      in_item_q.cpu_sel    <= s_axis_tuser[3];
      in_item_q.write_data <= s_axis_tdata[15:0];
      in_item_q.write_mask <= s_axis_tdata[31:16];
    end
  end

  dlts_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_item_q),
    .fire_i   (fire),
    .result_o (core_res)
  );

  dlts_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (core_res),
    .take_i   (m_axis_tready),
    .valid_o  (out_valid),
    .result_o (out_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res};

endmodule

### hdl/dlts_checker.sv
// Port-level checker for the display line timing block, bound to the top level.
module dlts_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  property p_stall_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("result changed while stalled");

  property p_vblank_entry;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[26] && m_axis_tdata[36:28] == 9'd192;
  endproperty
  a_vblank_entry: assert property (p_vblank_entry) else $error("vblank pulse off line 192");

  property p_hblank_render;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> m_axis_tdata[22] == m_axis_tdata[27];
  endproperty
  a_hblank_render: assert property (p_hblank_render) else $error("hblank dma and render split");

  property p_render3d_offscreen;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tdata[25] |-> !m_axis_tdata[27] && m_axis_tdata[15:0] == 16'h0;
  endproperty
  a_render3d_offscreen: assert property (p_render3d_offscreen)
    else $error("3d render on a visible line");

endmodule

bind display_line_timing_status dlts_assert u_dlts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/dlts_checker.sv
// Checker that predicts each display timing result and compares it with the block's output.
module dlts_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // write_data[15:0], write_mask[31:16]
  input  logic [3:0]  s_axis_tuser,   // req_type[2:0], cpu_sel[3]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // read_data .. screens_swapped, zero[39:38]
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dlts_pkg::*;

  localparam logic [8:0]  VisLines   = 9'd192;
  localparam logic [8:0]  FrameLines = 9'd263;
  localparam logic [8:0]  Line3d     = 9'd215;
  localparam logic [15:0] StatMask   = 16'hffbf;
  localparam logic [15:0] PwrMask    = 16'h820f;

  localparam int VblankBit   = 0;
  localparam int HblankBit   = 1;
  localparam int MatchBit    = 2;
  localparam int VblankIeBit = 3;
  localparam int HblankIeBit = 4;
  localparam int MatchIeBit  = 5;
  localparam int CmpHiBit    = 7;

  logic [8:0]   line_cnt;
  logic [15:0]  stat [2];
  logic [15:0]  power_reg;
  dlts_result_t outcome_q [$];
  dlts_result_t got, want;
  int           mismatch_cnt = 0;
  int           result_idx = 0;

  assign errors_o = mismatch_cnt;

  function automatic logic [15:0] merge(input logic [15:0] old, input logic [15:0] val,
                                        input logic [15:0] msk);
    return (old & ~msk) | (val & msk);
  endfunction

  function automatic dlts_result_t advance_timing(input logic [2:0] req, input logic sel,
                                                  input logic [15:0] wd,
                                                  input logic [15:0] wm);
    dlts_result_t r;
    logic [2:0]   irq [2];
    logic [8:0]   cmp;
    logic [15:0]  wide_line;
    r = '0;
    irq[0] = '0;
    irq[1] = '0;
    case (req)
      REQ_READ_STATUS: r.read_data = stat[sel];
      REQ_WRITE_STATUS: stat[sel] = merge(stat[sel], wd, wm & StatMask);
      REQ_WRITE_LINE: begin
        wide_line = merge({7'd0, line_cnt}, wd, wm);
        line_cnt = wide_line[8:0];
      end
      REQ_WRITE_POWER: power_reg = merge(power_reg, wd, wm & PwrMask);
      REQ_LINE_START: begin
        r.render_line = line_cnt < VisLines;
        r.dma_hblank = line_cnt < VisLines;
        r.dma_display_start = (line_cnt > 9'd1) && (line_cnt < VisLines + 9'd2);
        r.render_3d = line_cnt == Line3d;
        for (int c = 0; c < 2; c++) begin
          stat[c][HblankBit] = 1'b1;
          if (stat[c][HblankIeBit]) irq[c][HblankBit] = 1'b1;
        end
      end
      REQ_LINE_END: begin
        line_cnt = line_cnt + 9'd1;
        if (line_cnt == FrameLines) line_cnt = '0;
        for (int c = 0; c < 2; c++) stat[c][HblankBit] = 1'b0;
        if (line_cnt == VisLines) begin
          r.dma_vblank = 1'b1;
          r.swap_buffers = 1'b1;
          for (int c = 0; c < 2; c++) begin
            stat[c][VblankBit] = 1'b1;
            if (stat[c][VblankIeBit]) irq[c][VblankBit] = 1'b1;
          end
        end else if (line_cnt == FrameLines - 9'd1) begin
          for (int c = 0; c < 2; c++) stat[c][VblankBit] = 1'b0;
        end
        for (int c = 0; c < 2; c++) begin
          cmp = {stat[c][CmpHiBit], stat[c][15:8]};
          if (cmp == line_cnt) begin
            stat[c][MatchBit] = 1'b1;
            if (stat[c][MatchIeBit]) irq[c][MatchBit] = 1'b1;
          end else begin
            stat[c][MatchBit] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.cpu0_irq = irq[0];
    r.cpu1_irq = irq[1];
    r.current_line = line_cnt;
    r.screens_swapped = power_reg[15];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("result %0d: %s expected %0h, got %0h", result_idx, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt = '0;
      stat[0] = '0;
      stat[1] = '0;
      power_reg = '0;
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[37:0];
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d arrived with nothing expected: %h", result_idx, m_axis_tdata);
        end else begin
          want = outcome_q.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("cpu0_irq", 16'(want.cpu0_irq), 16'(got.cpu0_irq));
          check_field("cpu1_irq", 16'(want.cpu1_irq), 16'(got.cpu1_irq));
          check_field("dma_hblank", 16'(want.dma_hblank), 16'(got.dma_hblank));
          check_field("dma_vblank", 16'(want.dma_vblank), 16'(got.dma_vblank));
          check_field("dma_display_start", 16'(want.dma_display_start),
                      16'(got.dma_display_start));
          check_field("render_3d", 16'(want.render_3d), 16'(got.render_3d));
          check_field("swap_buffers", 16'(want.swap_buffers), 16'(got.swap_buffers));
          check_field("render_line", 16'(want.render_line), 16'(got.render_line));
          check_field("current_line", 16'(want.current_line), 16'(got.current_line));
          check_field("screens_swapped", 16'(want.screens_swapped),
                      16'(got.screens_swapped));
          check_field("pad", 16'd0, 16'(m_axis_tdata[39:38]));
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready)
        outcome_q.push_back(advance_timing(s_axis_tuser[2:0], s_axis_tuser[3],
                                           s_axis_tdata[15:0], s_axis_tdata[31:16]));
      pending_o <= outcome_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top: clock, reset, directed and random stimulus, and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlts_pkg::*;

  localparam int         CycleLimit  = 200000;
  localparam int         PhaseItems  = 242;
  localparam logic [2:0] ReqSpareLo  = 3'd6;
  localparam logic [2:0] ReqSpareHi  = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  int send_idle_pct = 32;
  int recv_stall_pct = 58;
  int fail_cnt;
  int pending_cnt;
  int cycle_cnt = 0;

  display_line_timing_status dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  dlts_checker status_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .errors_o (fail_cnt),
    .pending_o(pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic [2:0] req, input logic sel, input logic [15:0] wd,
                           input logic [15:0] wm);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {sel, req};
    s_axis_tdata <= {wm, wd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
  endtask

  function automatic logic [8:0] pick_line();
    case ($urandom_range(7))
      0: return 9'($urandom_range(3));
      1: return 9'($urandom_range(194, 189));
      2: return 9'($urandom_range(216, 213));
      3: return 9'($urandom_range(263, 259));
      4: return 9'($urandom_range(511, 505));
      default: return 9'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [15:0] wd;
    logic [15:0] wm;
    logic [8:0]  tgt;
    int          pick;
    wd = 16'($urandom);
    wm = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_item(REQ_LINE_END, 1'($urandom), wd, wm);
    end else if (pick < 50) begin
      send_item(REQ_LINE_START, 1'($urandom), wd, wm);
    end else if (pick < 60) begin
      send_item(REQ_READ_STATUS, 1'($urandom), wd, wm);
    end else if (pick < 73) begin
      if ($urandom_range(1)) wm = 16'hffff;
      if ($urandom_range(99) < 70) begin
        tgt = pick_line();
        wd[15:8] = tgt[7:0];
        wd[7] = tgt[8];
      end
      send_item(REQ_WRITE_STATUS, 1'($urandom), wd, wm);
    end else if (pick < 86) begin
      if ($urandom_range(3) != 0) wm = 16'hffff;
      wd[8:0] = pick_line();
      send_item(REQ_WRITE_LINE, 1'($urandom), wd, wm);
    end else if (pick < 94) begin
      send_item(REQ_WRITE_POWER, 1'($urandom), wd, wm);
    end else begin
      send_item($urandom_range(1) ? ReqSpareHi : ReqSpareLo, 1'($urandom), wd, wm);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(REQ_READ_STATUS, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_READ_STATUS, 1'b1, 16'hffff, 16'hffff);
    send_item(REQ_WRITE_STATUS, 1'b1, 16'hffff, 16'hffff);
    send_item(REQ_WRITE_STATUS, 1'b0, 16'h0138, 16'hffff);
    send_item(REQ_WRITE_POWER, 1'b0, 16'hffff, 16'hffff);
    send_item(REQ_READ_STATUS, 1'b1, 16'h0000, 16'h0000);
    send_item(REQ_LINE_START, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_LINE_END, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_WRITE_LINE, 1'b0, 16'hfebf, 16'hffff);
    send_item(REQ_LINE_START, 1'b1, 16'h0000, 16'h0000);
    send_item(REQ_LINE_END, 1'b1, 16'h0000, 16'h0000);
    send_item(REQ_LINE_START, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_LINE_END, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_LINE_START, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_WRITE_LINE, 1'b0, 16'h00d7, 16'h01ff);
    send_item(REQ_LINE_START, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_WRITE_LINE, 1'b0, 16'h0105, 16'h01ff);
    send_item(REQ_LINE_END, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_LINE_END, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_WRITE_STATUS, 1'b1, 16'hffa0, 16'hffff);
    send_item(REQ_WRITE_LINE, 1'b0, 16'h01fe, 16'hffff);
    send_item(REQ_LINE_END, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_LINE_END, 1'b0, 16'h0000, 16'h0000);
    send_item(REQ_WRITE_LINE, 1'b0, 16'h012c, 16'hffff);
    send_item(REQ_LINE_END, 1'b0, 16'h0000, 16'h0000);
    send_item(ReqSpareLo, 1'b1, 16'hffff, 16'hffff);
    send_item(ReqSpareHi, 1'b0, 16'hffff, 16'hffff);
    send_item(REQ_WRITE_POWER, 1'b0, 16'h0000, 16'h8000);
    send_item(REQ_WRITE_STATUS, 1'b0, 16'hffff, 16'h0000);

    for (int i = 0; i < PhaseItems; i++) send_random();
    wait_drained();

    send_idle_pct = 58;
    recv_stall_pct = 32;
    for (int i = 0; i < PhaseItems; i++) send_random();
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < PhaseItems; i++) send_random();
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### display_line_timing_status.f
hdl/dlts_pkg.sv
hdl/dlts_core.sv
hdl/dlts_out_stage.sv
hdl/display_line_timing_status.sv
hdl/dlts_checker.sv
verif/dlts_checker.sv
verif/tb_top.sv
